// ===== hdl/sliding_median_spike_detector_defines.svh =====
// ----------------------------------------------------------------------------
// Sliding median spike detector assertion macros
// Shared concurrent property wrappers for the detector RTL.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MEDIAN_SPIKE_DETECTOR_DEFINES_SVH
`define SLIDING_MEDIAN_SPIKE_DETECTOR_DEFINES_SVH

// same-cycle implication, held off while reset is asserted
`define SMSD_ASSERT_HOLDS(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is asserted
`define SMSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/smsd_pkg.sv =====
// ----------------------------------------------------------------------------
// smsd_pkg
// Widths, register indexes and cell link types for the median spike detector.
// ----------------------------------------------------------------------------
`default_nettype none

package smsd_pkg;

    localparam int SAMPLE_BITS        = 16;
    localparam int MEDIAN_BITS        = SAMPLE_BITS + 1;
    localparam int COUNT_BITS         = 32;
    localparam int CFG_BITS           = 7;
    localparam int WINDOW_MAX_DEFAULT = 64;
    localparam int APB_ADDR_BITS      = 3;
    localparam int APB_DATA_BITS      = 32;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    // handed from cell i+1 down to cell i
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] val;
        logic                   lt;
        logic                   eq;
    } smsd_up_t;

    // handed from cell i up to cell i+1: entry after the eviction step
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] r;
        logic                   lt_r;
    } smsd_dn_t;

    // broadcast to every cell
    typedef struct packed {
        logic                   go;
        logic                   full;
        logic [SAMPLE_BITS-1:0] sample;
        logic [SAMPLE_BITS-1:0] old;
    } smsd_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/smsd_cell.sv =====
// ----------------------------------------------------------------------------
// smsd_cell
// One slot of the sorted window: drops the leaving word and takes the new one.
// ----------------------------------------------------------------------------
`default_nettype none

module smsd_cell #(
    parameter int WINDOW_MAX = smsd_pkg::WINDOW_MAX_DEFAULT,
    parameter int INDEX      = 0,
    parameter int LEN_W      = $clog2(WINDOW_MAX + 1)
) (
    input  wire logic                 aclk,
    input  wire smsd_pkg::smsd_ctrl_t ctrl,
    input  wire logic [LEN_W-1:0]     occ_len,
    input  wire logic [LEN_W-1:0]     keep_len,
    input  wire smsd_pkg::smsd_up_t   up_in,
    output smsd_pkg::smsd_up_t        up_out,
    input  wire smsd_pkg::smsd_dn_t   dn_in,
    output smsd_pkg::smsd_dn_t        dn_out
);

    localparam logic [LEN_W-1:0] IDX_L = LEN_W'(INDEX);
    localparam bit FIRST = (INDEX == 0);

    logic [smsd_pkg::SAMPLE_BITS-1:0] val_reg;
    logic [smsd_pkg::SAMPLE_BITS-1:0] val_next;
    logic occ;
    logic keep;
    logic lt_own;
    logic eq_own;
    logic rm;
    logic above;
    logic ge;

    always_comb begin
        occ    = IDX_L < occ_len;
        keep   = IDX_L < keep_len;
        lt_own = val_reg < ctrl.sample;
        eq_own = occ && (val_reg == ctrl.old);
        // the last of a run of equal words is the one that leaves
        rm     = ctrl.full && eq_own && !up_in.eq;
        above  = ctrl.full && occ && (val_reg > ctrl.old);
        ge     = rm || above;

        up_out.val = val_reg;
        up_out.lt  = lt_own;
        up_out.eq  = eq_own;

        dn_out.r    = ge ? up_in.val : val_reg;
        dn_out.lt_r = keep && (ge ? up_in.lt : lt_own);

        if (dn_out.lt_r) begin
            val_next = dn_out.r;
        end else if (FIRST || dn_in.lt_r) begin
            val_next = ctrl.sample;
        end else begin
            val_next = dn_in.r;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.go) begin
            val_reg <= val_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/smsd_chain.sv =====
// ----------------------------------------------------------------------------
// smsd_chain
// Row of sorted window cells with registered pick of the two middle entries.
// ----------------------------------------------------------------------------
`default_nettype none

module smsd_chain #(
    parameter int WINDOW_MAX = smsd_pkg::WINDOW_MAX_DEFAULT,
    parameter int LEN_W      = $clog2(WINDOW_MAX + 1),
    parameter int IDX_W      = $clog2(WINDOW_MAX)
) (
    input  wire logic                             aclk,
    input  wire smsd_pkg::smsd_ctrl_t             ctrl,
    input  wire logic [LEN_W-1:0]                 occ_len,
    input  wire logic [LEN_W-1:0]                 keep_len,
    input  wire logic [IDX_W-1:0]                 lo_idx,
    input  wire logic [IDX_W-1:0]                 hi_idx,
    output logic      [smsd_pkg::SAMPLE_BITS-1:0] lo_val,
    output logic      [smsd_pkg::SAMPLE_BITS-1:0] hi_val
);

    smsd_pkg::smsd_up_t up_w [WINDOW_MAX];
    smsd_pkg::smsd_dn_t dn_w [WINDOW_MAX];

    logic [smsd_pkg::SAMPLE_BITS-1:0] lo_sel;
    logic [smsd_pkg::SAMPLE_BITS-1:0] hi_sel;
    logic [smsd_pkg::SAMPLE_BITS-1:0] lo_val_reg;
    logic [smsd_pkg::SAMPLE_BITS-1:0] hi_val_reg;

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        smsd_pkg::smsd_up_t up_in;
        smsd_pkg::smsd_dn_t dn_in;

        if (i == WINDOW_MAX - 1) begin : g_top_end
            assign up_in = '0;
        end else begin : g_top_link
            assign up_in = up_w[i+1];
        end

        if (i == 0) begin : g_bot_end
            assign dn_in = '0;
        end else begin : g_bot_link
            assign dn_in = dn_w[i-1];
        end

        smsd_cell #(
            .WINDOW_MAX (WINDOW_MAX),
            .INDEX      (i),
            .LEN_W      (LEN_W)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .occ_len  (occ_len),
            .keep_len (keep_len),
            .up_in    (up_in),
            .up_out   (up_w[i]),
            .dn_in    (dn_in),
            .dn_out   (dn_w[i])
        );
    end

    always_comb begin
        lo_sel = '0;
        hi_sel = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (IDX_W'(i) == lo_idx) begin
                lo_sel = up_w[i].val;
            end
            if (IDX_W'(i) == hi_idx) begin
                hi_sel = up_w[i].val;
            end
        end
    end

    // middle entries are sampled every cycle, the window only moves on go
    always_ff @(posedge aclk) begin
        lo_val_reg <= lo_sel;
        hi_val_reg <= hi_sel;
    end

    assign lo_val = lo_val_reg;
    assign hi_val = hi_val_reg;

endmodule

`default_nettype wire

// ===== hdl/sliding_median_spike_detector.sv =====
// ----------------------------------------------------------------------------
// sliding_median_spike_detector
// Sequence: a sample is taken in IDLE and its result word is registered on go
// in CALC, which an output stall holds off. No new sample is taken until CALC
// ends, as go waits on the registered reads of history ring and middle entries.
// Reset: synchronous, active low; clears control, window_length to 1, no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_median_spike_detector_defines.svh"

module sliding_median_spike_detector #(
    parameter int WINDOW_MAX = smsd_pkg::WINDOW_MAX_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // apb configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [smsd_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [smsd_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [smsd_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                    pready,
    // sample input
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [smsd_pkg::SAMPLE_BITS-1:0]   s_sample,
    // result output
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_alert,
    output logic                                    m_window_full,
    output logic      [smsd_pkg::MEDIAN_BITS-1:0]   m_median_doubled,
    output logic      [smsd_pkg::COUNT_BITS-1:0]    m_alert_total
);

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int CMP_W = (LEN_W > smsd_pkg::CFG_BITS) ? LEN_W : smsd_pkg::CFG_BITS;

    typedef enum logic {
        IDLE,
        CALC
    } state_t;

    state_t state_reg;

    logic [smsd_pkg::CFG_BITS-1:0]    wl_reg;
    logic [LEN_W-1:0]                 fill_reg;
    logic [IDX_W-1:0]                 ptr_reg;
    logic [smsd_pkg::COUNT_BITS-1:0]  cnt_reg;
    logic [smsd_pkg::SAMPLE_BITS-1:0] sample_reg;
    logic [smsd_pkg::SAMPLE_BITS-1:0] old_reg;

    logic                             m_valid_reg;
    logic                             m_alert_reg;
    logic                             m_window_full_reg;
    logic [smsd_pkg::MEDIAN_BITS-1:0] m_median_doubled_reg;
    logic [smsd_pkg::COUNT_BITS-1:0]  m_alert_total_reg;

    logic [smsd_pkg::SAMPLE_BITS-1:0] hist [WINDOW_MAX];

    logic [CMP_W-1:0]                 wl_x;
    logic [LEN_W-1:0]                 len;
    logic [LEN_W-1:0]                 half;
    logic [LEN_W-1:0]                 keep_len;
    logic [LEN_W-1:0]                 ptr_inc;
    logic [IDX_W-1:0]                 ptr_next;
    logic [IDX_W-1:0]                 lo_idx;
    logic [IDX_W-1:0]                 hi_idx;
    logic [IDX_W-1:0]                 wr_addr;
    logic                             full;
    logic                             go;
    logic                             cfg_wr;
    logic                             alert_now;
    logic [smsd_pkg::SAMPLE_BITS-1:0] lo_val;
    logic [smsd_pkg::SAMPLE_BITS-1:0] hi_val;
    logic [smsd_pkg::MEDIAN_BITS-1:0] med_sum;
    logic [smsd_pkg::COUNT_BITS-1:0]  cnt_next;
    smsd_pkg::smsd_ctrl_t             ctrl;

    always_comb begin
        wl_x = CMP_W'(wl_reg);
        if (wl_x == '0) begin
            len = LEN_W'(1);
        end else if (wl_x > CMP_W'(WINDOW_MAX)) begin
            len = LEN_W'(WINDOW_MAX);
        end else begin
            len = LEN_W'(wl_x);
        end

        full     = fill_reg >= len;
        keep_len = full ? (len - LEN_W'(1)) : fill_reg;

        // even length uses the two middle entries, odd the middle one twice
        half   = len >> 1;
        hi_idx = IDX_W'(half);
        lo_idx = len[0] ? IDX_W'(half) : IDX_W'(half - LEN_W'(1));

        ptr_inc  = LEN_W'(ptr_reg) + LEN_W'(1);
        ptr_next = (ptr_inc >= len) ? '0 : ptr_inc[IDX_W-1:0];
        wr_addr  = full ? ptr_reg : fill_reg[IDX_W-1:0];

        go     = (state_reg == CALC) && (!m_valid_reg || m_ready);
        cfg_wr = psel && penable && pwrite && (paddr[2] == smsd_pkg::REG_WINDOW_LENGTH);

        med_sum   = {1'b0, lo_val} + {1'b0, hi_val};
        alert_now = full && ({1'b0, sample_reg} >= med_sum);
        cnt_next  = (alert_now && (cnt_reg != '1)) ? (cnt_reg + 1'b1) : cnt_reg;

        ctrl.go     = go;
        ctrl.full   = full;
        ctrl.sample = sample_reg;
        ctrl.old    = old_reg;
    end

    smsd_chain #(
        .WINDOW_MAX (WINDOW_MAX),
        .LEN_W      (LEN_W),
        .IDX_W      (IDX_W)
    ) u_chain (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .occ_len  (len),
        .keep_len (keep_len),
        .lo_idx   (lo_idx),
        .hi_idx   (hi_idx),
        .lo_val   (lo_val),
        .hi_val   (hi_val)
    );

    // history ring: leaving word is read ahead while waiting for a sample
    always_ff @(posedge aclk) begin
        old_reg <= hist[ptr_reg];
        if (go) begin
            hist[wr_addr] <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
            wl_reg      <= smsd_pkg::CFG_BITS'(1);
            fill_reg    <= '0;
            ptr_reg     <= '0;
            cnt_reg     <= '0;
        end else begin
            if (cfg_wr) begin
                wl_reg   <= pwdata[smsd_pkg::CFG_BITS-1:0];
                fill_reg <= '0;
                ptr_reg  <= '0;
            end else if (go) begin
                if (full) begin
                    ptr_reg <= ptr_next;
                end else begin
                    fill_reg <= fill_reg + LEN_W'(1);
                end
            end

            unique case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        sample_reg <= s_sample;
                        state_reg  <= CALC;
                    end
                end
                CALC: begin
                    if (go) begin
                        state_reg <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase

            if (go) begin
                m_valid_reg          <= 1'b1;
                m_alert_reg          <= alert_now;
                m_window_full_reg    <= full;
                m_median_doubled_reg <= full ? med_sum : '0;
                m_alert_total_reg    <= cnt_next;
                cnt_reg              <= cnt_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready          = (state_reg == IDLE);
    assign pready           = 1'b1;
    assign prdata           = (paddr[2] == smsd_pkg::REG_WINDOW_LENGTH) ?
                              smsd_pkg::APB_DATA_BITS'(wl_reg) : '0;
    assign m_valid          = m_valid_reg;
    assign m_alert          = m_alert_reg;
    assign m_window_full    = m_window_full_reg;
    assign m_median_doubled = m_median_doubled_reg;
    assign m_alert_total    = m_alert_total_reg;

    `SMSD_ASSERT_HOLDS(a_fill_in_range, aclk, aresetn, 1'b1, fill_reg <= len, "fill past window")
    `SMSD_ASSERT_HOLDS(a_ptr_in_range, aclk, aresetn, full, LEN_W'(ptr_reg) < len, "ring pointer past window")
    `SMSD_ASSERT_NEXT(a_cnt_monotonic, aclk, aresetn, go, cnt_reg >= $past(cnt_reg), "alert total fell")
    `SMSD_ASSERT_NEXT(a_empty_no_alert, aclk, aresetn, go && !full, !m_alert && (m_median_doubled == '0), "alert before full window")

endmodule

`default_nettype wire

// ===== sim/sliding_median_spike_detector_tb.sv =====
// ----------------------------------------------------------------------------
// sliding_median_spike_detector_tb
// Streams samples through the median spike detector and checks every result
// word against a sorted-window predictor kept alongside. The window length is
// reprogrammed over APB between bursts (odd, even, zero, oversized), and both
// sides of the stream idle at random, with one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_median_spike_detector_tb;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SHOWN_ERRORS  = 10;
    localparam int SEGMENT_COUNT = 9;

    localparam logic [smsd_pkg::APB_ADDR_BITS-1:0] WINDOW_LENGTH_ADDR =
        {smsd_pkg::REG_WINDOW_LENGTH, 2'b00};
    localparam logic [smsd_pkg::APB_ADDR_BITS-1:0] SPARE_REG_ADDR =
        {~smsd_pkg::REG_WINDOW_LENGTH, 2'b00};

    typedef struct packed {
        logic                             alert;
        logic                             window_full;
        logic [smsd_pkg::MEDIAN_BITS-1:0] median_doubled;
        logic [smsd_pkg::COUNT_BITS-1:0]  alert_total;
    } spike_verdict_t;

    logic                               aclk    = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               psel    = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite  = 1'b0;
    logic [smsd_pkg::APB_ADDR_BITS-1:0] paddr   = '0;
    logic [smsd_pkg::APB_DATA_BITS-1:0] pwdata  = '0;
    logic [smsd_pkg::APB_DATA_BITS-1:0] prdata;
    logic                               pready;
    logic                               s_valid  = 1'b0;
    logic                               s_ready;
    logic [smsd_pkg::SAMPLE_BITS-1:0]   s_sample = '0;
    logic                               m_valid;
    logic                               m_ready  = 1'b0;
    logic                               m_alert;
    logic                               m_window_full;
    logic [smsd_pkg::MEDIAN_BITS-1:0]   m_median_doubled;
    logic [smsd_pkg::COUNT_BITS-1:0]    m_alert_total;

    // predictor state
    logic [smsd_pkg::SAMPLE_BITS-1:0] ordered_window [smsd_pkg::WINDOW_MAX_DEFAULT];
    logic [smsd_pkg::SAMPLE_BITS-1:0] arrival_ring [smsd_pkg::WINDOW_MAX_DEFAULT];
    logic [smsd_pkg::CFG_BITS-1:0]    window_length_reg = 7'd1;
    int                               window_fill = 0;
    int                               oldest_slot = 0;
    logic [smsd_pkg::COUNT_BITS-1:0]  alerts_seen = '0;

    logic [smsd_pkg::SAMPLE_BITS-1:0] sample_queue [$];
    spike_verdict_t                   verdict_queue [$];
    spike_verdict_t                   wanted_verdict;
    spike_verdict_t                   seen_verdict;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    sliding_median_spike_detector #(
        .WINDOW_MAX(smsd_pkg::WINDOW_MAX_DEFAULT)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_alert         (m_alert),
        .m_window_full   (m_window_full),
        .m_median_doubled(m_median_doubled),
        .m_alert_total   (m_alert_total)
    );

    function automatic int effective_length(input logic [smsd_pkg::CFG_BITS-1:0] raw);
        if (raw == 0) begin
            return 1;
        end
        if (raw > smsd_pkg::WINDOW_MAX_DEFAULT) begin
            return smsd_pkg::WINDOW_MAX_DEFAULT;
        end
        return int'(raw);
    endfunction

    function automatic void enqueue_sample(input logic [smsd_pkg::SAMPLE_BITS-1:0] smp);
        sample_queue.insert(sample_queue.size(), smp);
    endfunction

    function automatic void place_sorted(input int n,
                                         input logic [smsd_pkg::SAMPLE_BITS-1:0] smp);
        int p;
        int i;
        p = 0;
        while (p < n && ordered_window[p] < smp) p++;
        for (i = n; i > p; i--) ordered_window[i] = ordered_window[i-1];
        ordered_window[p] = smp;
    endfunction

    function automatic spike_verdict_t slide_window(
        input logic [smsd_pkg::SAMPLE_BITS-1:0] smp);
        spike_verdict_t                   v;
        int                               len;
        int                               half;
        int                               pos;
        int                               i;
        logic [smsd_pkg::SAMPLE_BITS-1:0] leaving;
        v   = '0;
        len = effective_length(window_length_reg);
        if (window_fill >= len) begin
            half          = len / 2;
            v.window_full = 1'b1;
            if (len % 2 == 0) begin
                v.median_doubled = {1'b0, ordered_window[half-1]} + {1'b0, ordered_window[half]};
            end else begin
                v.median_doubled = {ordered_window[half], 1'b0};
            end
            if ({1'b0, smp} >= v.median_doubled) begin
                v.alert = 1'b1;
                if (alerts_seen != '1) alerts_seen++;
            end
            if (oldest_slot >= len) oldest_slot = 0;
            leaving                   = arrival_ring[oldest_slot];
            arrival_ring[oldest_slot] = smp;
            oldest_slot               = (oldest_slot + 1 >= len) ? 0 : oldest_slot + 1;
            // evict one copy of the leaving sample, any of several equals will do
            pos = len;
            for (i = 0; i < len; i++) begin
                if (pos == len && ordered_window[i] == leaving) pos = i;
            end
            if (pos == len) pos = len - 1;
            for (i = pos; i + 1 < len; i++) ordered_window[i] = ordered_window[i+1];
            place_sorted(len - 1, smp);
        end else begin
            arrival_ring[window_fill] = smp;
            place_sorted(window_fill, smp);
            window_fill++;
        end
        v.alert_total = alerts_seen;
        return v;
    endfunction

    // mostly a quiet baseline with spikes, plus full-range and edge values
    function automatic logic [smsd_pkg::SAMPLE_BITS-1:0] draw_sample();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) begin
            return smsd_pkg::SAMPLE_BITS'($urandom_range(800, 200));
        end
        if (r < 72) begin
            return smsd_pkg::SAMPLE_BITS'($urandom_range(4000, 1000));
        end
        if (r < 86) begin
            return smsd_pkg::SAMPLE_BITS'($urandom);
        end
        if (r < 93) begin
            return '0;
        end
        return '1;
    endfunction

    task automatic apb_write(input logic [smsd_pkg::APB_ADDR_BITS-1:0] addr,
                             input logic [smsd_pkg::APB_DATA_BITS-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == smsd_pkg::REG_WINDOW_LENGTH) begin
            window_length_reg = data[smsd_pkg::CFG_BITS-1:0];
            window_fill       = 0;
            oldest_slot       = 0;
        end
        @(negedge aclk);
    endtask

    task automatic drain_results();
        while (sample_queue.size() != 0 || s_valid || verdict_queue.size() != 0) begin
            @(negedge aclk);
        end
        repeat (3) @(negedge aclk);
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                verdict_queue.insert(verdict_queue.size(), slide_window(s_sample));
            end
            if (!s_valid || s_ready) begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid  <= 1'b1;
                    s_sample <= sample_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // output back-pressure, with one long stall on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_verdict = '{m_alert, m_window_full, m_median_doubled, m_alert_total};
            if (verdict_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS) begin
                    $display("unexpected result word: alert %0d full %0d median2 %0d total %0d",
                             m_alert, m_window_full, m_median_doubled, m_alert_total);
                end
            end else begin
                wanted_verdict = verdict_queue.pop_front();
                if (seen_verdict !== wanted_verdict) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS) begin
                        $display("result word differs: alert %0d/%0d full %0d/%0d",
                                 wanted_verdict.alert, seen_verdict.alert,
                                 wanted_verdict.window_full, seen_verdict.window_full);
                        $display("  median2 %0d/%0d total %0d/%0d (expected/actual)",
                                 wanted_verdict.median_doubled, seen_verdict.median_doubled,
                                 wanted_verdict.alert_total, seen_verdict.alert_total);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int seg_lengths [SEGMENT_COUNT];
        int seg;
        int span;
        seg_lengths = '{64, 3, 2, 127, 1, 17, 65, 8, 1};
        seg_lengths[4] = $urandom_range(smsd_pkg::WINDOW_MAX_DEFAULT, 1);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_idle_pct = 15;
        recv_idle_pct = 47;

        // length one out of reset: extremes, repeats and alternating bits
        enqueue_sample(16'h0000); enqueue_sample(16'h0000);
        enqueue_sample(16'hFFFF); enqueue_sample(16'h7FFF);
        enqueue_sample(16'h8000); enqueue_sample(16'h5555);
        enqueue_sample(16'hAAAA); enqueue_sample(16'h0001);
        drain_results();

        // write to a register that does not exist, then length zero with junk above
        apb_write(SPARE_REG_ADDR, 32'd9);
        apb_write(WINDOW_LENGTH_ADDR, 32'hFFFF_FF80);
        enqueue_sample(16'd5); enqueue_sample(16'd10);
        enqueue_sample(16'd4); enqueue_sample(16'd9);
        drain_results();

        // even window full of equal values
        apb_write(WINDOW_LENGTH_ADDR, 32'd4);
        enqueue_sample(16'd7);  enqueue_sample(16'd7);
        enqueue_sample(16'd7);  enqueue_sample(16'd7);
        enqueue_sample(16'd14); enqueue_sample(16'd13);
        enqueue_sample(16'd7);  enqueue_sample(16'd30);
        drain_results();

        for (seg = 0; seg < SEGMENT_COUNT; seg++) begin
            if (seg == 3) begin
                send_idle_pct = 47;
                recv_idle_pct = 15;
            end else if (seg == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apb_write(WINDOW_LENGTH_ADDR, smsd_pkg::APB_DATA_BITS'(seg_lengths[seg]));
            span = 60 + 2 * effective_length(smsd_pkg::CFG_BITS'(seg_lengths[seg]));
            repeat (span) enqueue_sample(draw_sample());
            // long stall while the sender keeps offering words
            if (seg == 6) hold_requests++;
            drain_results();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && verdict_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
